// ===== src/chs_pkg.sv =====
// shared constants and types of the chained hash set
package chs_pkg;

	localparam int NUM_BUCKETS  = 128;
	localparam int BUCKET_SLOTS = 8;
	localparam int KEY_BITS     = 20;

	localparam int ROW_BITS = $clog2(NUM_BUCKETS);
	localparam int ROW_W    = BUCKET_SLOTS * KEY_BITS;

	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [BUCKET_SLOTS-1:0][KEY_BITS-1:0] key_row_t;
	typedef logic [BUCKET_SLOTS-1:0] slot_vec_t;

	// request codes; the unused code acts as a query
	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2
	} req_t;

endpackage

// ===== src/chs_ram.sv =====
// generic simple dual-port ram with registered read
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/chained_hash_set.sv =====
// top level of the chained hash set: bucket rows in ram, read-modify-write per request
// Usage:
//   A request beat (req_type, key) is taken at a rising edge with start high and
//   busy low. req_type: add, remove or query; the unused code acts as a query.
//   The bucket is the low bits of the key; each bucket holds a fixed number of
//   slots, kept as one row of keys and one row of valid bits in two rams.
//   Timing: the accept edge registers the bucket row read; in the next cycle
//   busy is high, the slots are compared in parallel and the row is written
//   back at the following edge. The result beat (was_present, bucket_full) is
//   shown for one cycle with done high, starting at that write edge.
//   No new request is taken while one is in flight, since each request has a
//   single row read and write-back; busy drops in time for the next start.
//   Reset: arst_n clears busy, done and the per-row written marks, so every
//   bucket reads as empty; no clearing pass is needed.
//   The receiver cannot stall: each result beat lasts exactly one cycle.
module chained_hash_set
	import chs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic                was_present,
	output logic                bucket_full
);

	logic                   accept;
	logic                   busy_q;
	logic [1:0]             req_s1;
	key_t                   key_s1;
	row_t                   row_s1;
	logic [NUM_BUCKETS-1:0] row_init_q;
	logic                   done_q;
	logic                   was_present_q;
	logic                   bucket_full_q;

	logic [ROW_W-1:0]        key_rd;
	logic [BUCKET_SLOTS-1:0] valid_rd;
	key_row_t                keys_old;
	key_row_t                keys_new;
	slot_vec_t               valid_old;
	slot_vec_t               valid_new;
	slot_vec_t               match;
	slot_vec_t               free_vec;
	slot_vec_t               ins_oh;
	logic                    hit;
	logic                    has_free;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// bucket row memories, read at the accept edge, written back at the end of the following busy cycle
	chs_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_BUCKETS)
	) u_key_ram (
		.clk   (clk),
		.we    (busy_q),
		.waddr (row_s1),
		.wdata (keys_new),
		.raddr (key[ROW_BITS-1:0]),
		.rdata (key_rd)
	);

	chs_ram #(
		.WIDTH (BUCKET_SLOTS),
		.DEPTH (NUM_BUCKETS)
	) u_valid_ram (
		.clk   (clk),
		.we    (busy_q),
		.waddr (row_s1),
		.wdata (valid_new),
		.raddr (key[ROW_BITS-1:0]),
		.rdata (valid_rd)
	);

	// request capture and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			key_s1 <= key;
			row_s1 <= key[ROW_BITS-1:0];
		end
	end

	// rows never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (busy_q) begin
			row_init_q[row_s1] <= 1'b1;
		end
	end

	assign keys_old  = key_row_t'(key_rd);
	assign valid_old = row_init_q[row_s1] ? valid_rd : '0;

	// parallel slot compare
	always_comb begin
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			match[s] = valid_old[s] && (keys_old[s] == key_s1);
		end
	end

	assign hit      = |match;
	assign free_vec = ~valid_old;
	assign has_free = |free_vec;
	// lowest free slot as one-hot
	assign ins_oh   = free_vec & (~free_vec + slot_vec_t'(1));

	// row update
	always_comb begin
		keys_new  = keys_old;
		valid_new = valid_old;
		case (req_s1)
			REQ_ADD: begin
				if (!hit && has_free) begin
					valid_new = valid_old | ins_oh;
					for (int s = 0; s < BUCKET_SLOTS; s++) begin
						if (ins_oh[s]) begin
							keys_new[s] = key_s1;
						end
					end
				end
			end
			REQ_REMOVE: begin
				valid_new = valid_old & ~match;
			end
			default: begin
				valid_new = valid_old;
			end
		endcase
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			was_present_q <= hit;
			bucket_full_q <= (req_s1 == REQ_ADD) && !hit && !has_free;
		end
	end

	assign done        = done_q;
	assign was_present = was_present_q;
	assign bucket_full = bucket_full_q;

endmodule
